// File: rtl/core/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length line encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package pcxrle_pkg;

   localparam int unsigned PixelW = 8;
   localparam int unsigned CountW = 6;

   localparam logic [CountW-1:0] MaxRun  = 6'd63;
   localparam logic [PixelW-1:0] RepMark = 8'hC0;

   // One accepted pixel's work: an optional flush of the old run (a_*) and,
   // at the end of a line, the flush of the run that is pending then (b_*).
   typedef struct packed {
      logic              a_vld;
      logic [PixelW-1:0] a_val;
      logic [CountW-1:0] a_cnt;
      logic              b_vld;
      logic [PixelW-1:0] b_val;
      logic [CountW-1:0] b_cnt;
   } run_pair_type;

   // Queue status seen by the front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // A run needs a repeat byte unless it is one pixel with the top bits clear.
   function automatic logic needs_rep(input logic [PixelW-1:0] val,
                                      input logic [CountW-1:0] cnt);
      needs_rep = (cnt != CountW'(1)) || ((val & RepMark) != '0);
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcx_rle_line_encoder_core.sv
// Top level of the PCX run-length line encoder: front, work queue, back.
// Depends on pcxrle_pkg, pcxrle_front, pcxrle_queue and pcxrle_back.
`default_nettype none

// Channel   Ports                           Payload (low bit first)
// req       req_tvalid/tready/tdata/tlast   tdata[7:0] pixel; tlast last_in_line
// rsp       rsp_tvalid/tready/tdata/tuser/  tdata[7:0] code_byte; tuser last;
//           tlast                           tlast line_done
//
// A pixel is taken each cycle while the work queue has room; the front keeps
// the pending run and queues flush work only for pixels that end a run.
// The back sends one code byte a cycle while rsp is ready; an item makes 1 to 4
// bytes (2 per pixel when every pixel is a lone value with high bits set).
// An item's first byte passes through the queue, cur_ff and the output register.
// Reset is synchronous and empties the run state, queue and output stage.
// A stall on rsp fills the queue and only then drops req_tready.

module pcx_rle_line_encoder_core #(
   parameter int unsigned QueueDepth = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // [7:0] pixel
   input  wire         req_tlast,    // last_in_line
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] code_byte
   output logic        rsp_tuser,    // last: final byte caused by one item
   output logic        rsp_tlast     // line_done: final byte of a scan line
);
   import pcxrle_pkg::*;

   run_pair_type push_entry;
   run_pair_type head_entry;
   q_stat_type   q_stat;
   logic         push, pop;

   // run tracking and classification
   pcxrle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   // decouples pixel intake from byte output
   pcxrle_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .head      (head_entry),
      .stat      (q_stat)
   );

   // byte sequencer and output register
   pcxrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (head_entry),
      .q_stat     (q_stat),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: rtl/core/pcxrle_front.sv
// Front end: accepts pixels, tracks the pending run and queues flush work.
// Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [7:0]                  req_tdata,   // [7:0] pixel
   input  wire                         req_tlast,   // last_in_line
   input  pcxrle_pkg::q_stat_type      q_stat,
   output logic                        q_push,
   output pcxrle_pkg::run_pair_type    q_entry
);
   import pcxrle_pkg::*;

   logic [PixelW-1:0] run_val_ff, run_val_in;
   logic [CountW-1:0] run_len_ff, run_len_in;
   logic              accept;
   logic              flush_a;
   logic              start;
   logic [PixelW-1:0] val_new;
   logic [CountW-1:0] len_new;

   assign req_tready = ~q_stat.full;
   assign accept     = req_tvalid & ~q_stat.full;

   always_comb begin
      flush_a = (run_len_ff != '0) &&
                ((req_tdata != run_val_ff) || (run_len_ff == MaxRun));
      start   = flush_a || (run_len_ff == '0);
      val_new = start ? req_tdata : run_val_ff;
      len_new = start ? CountW'(1) : run_len_ff + CountW'(1);

      q_entry.a_vld = flush_a;
      q_entry.a_val = run_val_ff;
      q_entry.a_cnt = run_len_ff;
      q_entry.b_vld = req_tlast;
      q_entry.b_val = val_new;
      q_entry.b_cnt = len_new;

      q_push = accept && (flush_a || req_tlast);

      run_val_in = run_val_ff;
      run_len_in = run_len_ff;
      if (accept) begin
         // run state clears at the end of every line
         run_val_in = req_tlast ? '0 : val_new;
         run_len_in = req_tlast ? '0 : len_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_val_ff <= '0;
         run_len_ff <= '0;
      end else begin
         run_val_ff <= run_val_in;
         run_len_ff <= run_len_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/pcxrle_queue.sv
// Short register queue of flush work between front and back.
// Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_queue #(
   parameter int unsigned Depth = 4
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  pcxrle_pkg::run_pair_type    push_data,
   input  wire                         pop,
   output pcxrle_pkg::run_pair_type    head,
   output pcxrle_pkg::q_stat_type      stat
);
   import pcxrle_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   run_pair_type    slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign stat.full  = (count_ff == CntW'(Depth));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head       = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CntW'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slots_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// File: rtl/core/pcxrle_back.sv
// Back end: expands queued flush work into PCX code bytes, one a cycle,
// through a registered output stage, unless rsp stalls. Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_back (
   input  wire                         clock,
   input  wire                         reset,
   input  pcxrle_pkg::run_pair_type    q_head,
   input  pcxrle_pkg::q_stat_type      q_stat,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] code_byte
   output logic                        rsp_tuser,   // last (final byte of an item)
   output logic                        rsp_tlast    // line_done
);
   import pcxrle_pkg::*;

   typedef enum logic [1:0] {PH_AREP, PH_AVAL, PH_BREP, PH_BVAL} phase_type;

   run_pair_type      cur_ff, cur_in;
   logic              cur_vld_ff, cur_vld_in;
   phase_type         ph_ff, ph_in;
   logic              out_vld_ff, out_vld_in;
   logic [PixelW-1:0] out_byte_ff, out_byte_in;
   logic              out_item_ff, out_item_in;
   logic              out_line_ff, out_line_in;

   logic              load, emit, done;
   phase_type         ph_next, ph_first;
   logic [PixelW-1:0] byte_now;

   always_comb begin
      load = ~out_vld_ff | rsp_tready;
      emit = cur_vld_ff & load;

      unique case (ph_ff)
         PH_AREP: byte_now = RepMark | PixelW'(cur_ff.a_cnt);
         PH_AVAL: byte_now = cur_ff.a_val;
         PH_BREP: byte_now = RepMark | PixelW'(cur_ff.b_cnt);
         PH_BVAL: byte_now = cur_ff.b_val;
         default: byte_now = cur_ff.b_val;
      endcase

      done    = 1'b0;
      ph_next = ph_ff;
      unique case (ph_ff)
         PH_AREP: ph_next = PH_AVAL;
         PH_AVAL: begin
            if (cur_ff.b_vld)
               ph_next = needs_rep(cur_ff.b_val, cur_ff.b_cnt) ? PH_BREP : PH_BVAL;
            else
               done = 1'b1;
         end
         PH_BREP: ph_next = PH_BVAL;
         PH_BVAL: done = 1'b1;
         default: done = 1'b1;
      endcase
      done = done & emit;

      if (q_head.a_vld)
         ph_first = needs_rep(q_head.a_val, q_head.a_cnt) ? PH_AREP : PH_AVAL;
      else
         ph_first = needs_rep(q_head.b_val, q_head.b_cnt) ? PH_BREP : PH_BVAL;

      q_pop = (~cur_vld_ff | done) & ~q_stat.empty;

      cur_in     = cur_ff;
      cur_vld_in = cur_vld_ff;
      ph_in      = ph_ff;
      if (~cur_vld_ff | done) begin
         cur_vld_in = ~q_stat.empty;
         if (~q_stat.empty) begin
            cur_in = q_head;
            ph_in  = ph_first;
         end
      end else if (emit) begin
         ph_in = ph_next;
      end

      out_vld_in  = out_vld_ff & ~rsp_tready;
      out_byte_in = out_byte_ff;
      out_item_in = out_item_ff;
      out_line_in = out_line_ff;
      if (emit) begin
         out_vld_in  = 1'b1;
         out_byte_in = byte_now;
         out_item_in = done;
         out_line_in = done & cur_ff.b_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         ph_ff      <= PH_AREP;
         out_vld_ff <= 1'b0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         ph_ff      <= ph_in;
         out_vld_ff <= out_vld_in;
      end
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_item_ff <= out_item_in;
      out_line_ff <= out_line_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_item_ff;
   assign rsp_tlast  = out_line_ff;

endmodule

`default_nettype wire
